// ----- design/i2cbb_pkg.sv -----
`default_nettype none

package i2cbb_pkg;

   // command codes as carried on the request op field
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_WAIT  = 3'd4;
   localparam logic [2:0] OP_READ  = 3'd5;

   // configuration register indexes
   localparam logic CSR_TICKS_PER_US = 1'b0;
   localparam logic CSR_ACK_TIMEOUT  = 1'b1;

   localparam logic [9:0] TICKS_PER_US_RST = 10'd150;
   localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

   // phase delays in microseconds
   localparam logic [2:0] DLY_1US = 3'd1;
   localparam logic [2:0] DLY_2US = 3'd2;
   localparam logic [2:0] DLY_5US = 3'd5;
   localparam logic [2:0] DLY_6US = 3'd6;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_WAIT_ACK,
      CMD_READ
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic       ack_missing;
      logic [7:0] rx_data;
   } result_type;

   typedef struct packed {
      logic [9:0] ticks_per_us;
      logic [7:0] ack_timeout;
   } cfg_type;

endpackage

`default_nettype wire

// ----- design/i2cbb_front.sv -----
`default_nettype none

module i2cbb_front
   import i2cbb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [2:0] op,
   input  wire logic [7:0] tx_byte,
   input  wire logic       send_ack,
   input  wire logic       sda_in,
   output logic            item_valid,
   input  wire logic       item_pop,
   output item_type        item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;
   item_type   decoded;

   // classify the op code; unused codes travel as plain ticks
   always_comb begin
      decoded.tx_byte  = tx_byte;
      decoded.send_ack = send_ack;
      decoded.sda_in   = sda_in;
      unique case (op)
         OP_START: decoded.cmd = CMD_START;
         OP_STOP:  decoded.cmd = CMD_STOP;
         OP_WRITE: decoded.cmd = CMD_WRITE;
         OP_WAIT:  decoded.cmd = CMD_WAIT_ACK;
         OP_READ:  decoded.cmd = CMD_READ;
         default:  decoded.cmd = CMD_NONE;
      endcase
   end

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

// ----- design/i2cbb_seq.sv -----
`default_nettype none

module i2cbb_seq
   import i2cbb_pkg::*;
#(
   parameter int PRESCALE_WIDTH = 10
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     item_valid,
   output logic          item_pop,
   input  wire item_type item,
   input  wire logic     rsp_full,
   output logic          rsp_push,
   output result_type    rsp_data
);

   localparam int CW = (PRESCALE_WIDTH + 1 > 11) ? PRESCALE_WIDTH + 1 : 11;
   localparam logic [PRESCALE_WIDTH-1:0] PRE_MAX = {PRESCALE_WIDTH{1'b1}};

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ST_A,
      PH_ST_B,
      PH_SP_A,
      PH_SP_B,
      PH_WA_A,
      PH_WA_B,
      PH_POLL,
      PH_WR_A,
      PH_WR_B,
      PH_WR_C,
      PH_RD_A,
      PH_RD_B,
      PH_AK_A,
      PH_AK_B
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [3:0]                bit_index_ff, bit_index_in;
   logic [7:0]                shift_data_ff, shift_data_in;
   logic [2:0]                us_rem_ff, us_rem_in;
   logic [PRESCALE_WIDTH-1:0] prescale_ff, prescale_in;
   logic [7:0]                poll_count_ff, poll_count_in;
   logic                      scl_ff, scl_in;
   logic                      sda_ff, sda_in_next;
   logic                      ack_flag_ff, ack_flag_in;
   logic                      miss_ff, miss_in;
   logic [7:0]                rx_hold_ff, rx_hold_in;
   logic                      done_in;
   logic                      fire;
   logic [PRESCALE_WIDTH:0]   pre_inc;
   logic                      us_end;
   logic [3:0]                bit_inc;
   logic [7:0]                rd_shift;

   assign fire     = item_valid && !rsp_full;
   assign item_pop = fire;
   assign rsp_push = fire;

   assign pre_inc  = {1'b0, prescale_ff} + {{PRESCALE_WIDTH{1'b0}}, 1'b1};
   assign us_end   = (prescale_ff == PRE_MAX) || (CW'(pre_inc) >= CW'(cfg.ticks_per_us));
   assign bit_inc  = bit_index_ff + 4'd1;
   assign rd_shift = {shift_data_ff[6:0], item.sda_in};

   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      shift_data_in = shift_data_ff;
      us_rem_in     = us_rem_ff;
      prescale_in   = prescale_ff;
      poll_count_in = poll_count_ff;
      scl_in        = scl_ff;
      sda_in_next   = sda_ff;
      ack_flag_in   = ack_flag_ff;
      miss_in       = miss_ff;
      rx_hold_in    = rx_hold_ff;
      done_in       = 1'b0;

      if (phase_ff == PH_IDLE && item.cmd != CMD_NONE) begin
         // command start
         miss_in       = 1'b0;
         bit_index_in  = 4'd0;
         poll_count_in = 8'd0;
         prescale_in   = '0;
         unique case (item.cmd)
            CMD_START: begin
               sda_in_next = 1'b1;
               scl_in      = 1'b1;
               us_rem_in   = DLY_5US;
               phase_in    = PH_ST_A;
            end
            CMD_STOP: begin
               sda_in_next = 1'b0;
               scl_in      = 1'b1;
               us_rem_in   = DLY_6US;
               phase_in    = PH_SP_A;
            end
            CMD_WRITE: begin
               scl_in        = 1'b0;
               sda_in_next   = item.tx_byte[7];
               shift_data_in = {item.tx_byte[6:0], 1'b0};
               us_rem_in     = DLY_2US;
               phase_in      = PH_WR_A;
            end
            CMD_WAIT_ACK: begin
               sda_in_next = 1'b1;
               us_rem_in   = DLY_1US;
               phase_in    = PH_WA_A;
            end
            default: begin
               shift_data_in = 8'd0;
               ack_flag_in   = item.send_ack;
               sda_in_next   = 1'b1;
               scl_in        = 1'b0;
               us_rem_in     = DLY_2US;
               phase_in      = PH_RD_A;
            end
         endcase
      end else if (phase_ff == PH_POLL) begin
         priority if (!item.sda_in) begin
            scl_in   = 1'b0;
            phase_in = PH_IDLE;
            done_in  = 1'b1;
         end else if (poll_count_ff >= cfg.ack_timeout) begin
            // no acknowledge: issue a stop with scl high
            miss_in     = 1'b1;
            sda_in_next = 1'b0;
            scl_in      = 1'b1;
            us_rem_in   = DLY_6US;
            prescale_in = '0;
            phase_in    = PH_SP_A;
         end else begin
            poll_count_in = poll_count_ff + 8'd1;
         end
      end else if (phase_ff != PH_IDLE) begin
         if (us_rem_ff != 3'd0) begin
            if (us_end) begin
               prescale_in = '0;
               us_rem_in   = us_rem_ff - 3'd1;
            end else begin
               prescale_in = pre_inc[PRESCALE_WIDTH-1:0];
            end
         end
         if (us_rem_in == 3'd0) begin
            unique case (phase_ff)
               PH_ST_A: begin
                  sda_in_next = 1'b0;
                  us_rem_in   = DLY_6US;
                  prescale_in = '0;
                  phase_in    = PH_ST_B;
               end
               PH_ST_B: begin
                  scl_in   = 1'b0;
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
               PH_SP_A: begin
                  sda_in_next = 1'b1;
                  us_rem_in   = DLY_6US;
                  prescale_in = '0;
                  phase_in    = PH_SP_B;
               end
               PH_SP_B: begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
               PH_WA_A: begin
                  scl_in      = 1'b1;
                  us_rem_in   = DLY_1US;
                  prescale_in = '0;
                  phase_in    = PH_WA_B;
               end
               PH_WA_B: begin
                  poll_count_in = 8'd0;
                  phase_in      = PH_POLL;
               end
               PH_WR_A: begin
                  scl_in      = 1'b1;
                  us_rem_in   = DLY_2US;
                  prescale_in = '0;
                  phase_in    = PH_WR_B;
               end
               PH_WR_B: begin
                  scl_in      = 1'b0;
                  us_rem_in   = DLY_2US;
                  prescale_in = '0;
                  phase_in    = PH_WR_C;
               end
               PH_WR_C: begin
                  bit_index_in = bit_inc;
                  if (bit_inc >= BITS_PER_BYTE) begin
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end else begin
                     sda_in_next   = shift_data_ff[7];
                     shift_data_in = {shift_data_ff[6:0], 1'b0};
                     us_rem_in     = DLY_2US;
                     prescale_in   = '0;
                     phase_in      = PH_WR_A;
                  end
               end
               PH_RD_A: begin
                  scl_in      = 1'b1;
                  us_rem_in   = DLY_1US;
                  prescale_in = '0;
                  phase_in    = PH_RD_B;
               end
               PH_RD_B: begin
                  shift_data_in = rd_shift;
                  bit_index_in  = bit_inc;
                  scl_in        = 1'b0;
                  us_rem_in     = DLY_2US;
                  prescale_in   = '0;
                  if (bit_inc >= BITS_PER_BYTE) begin
                     rx_hold_in  = rd_shift;
                     sda_in_next = !ack_flag_ff;
                     phase_in    = PH_AK_A;
                  end else begin
                     phase_in = PH_RD_A;
                  end
               end
               PH_AK_A: begin
                  scl_in      = 1'b1;
                  us_rem_in   = DLY_5US;
                  prescale_in = '0;
                  phase_in    = PH_AK_B;
               end
               PH_AK_B: begin
                  scl_in   = 1'b0;
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_comb begin
      rsp_data.scl_out     = scl_in;
      rsp_data.sda_out     = sda_in_next;
      rsp_data.busy_res    = (phase_in != PH_IDLE);
      rsp_data.done_res    = done_in;
      rsp_data.ack_missing = miss_in;
      rsp_data.rx_data     = rx_hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_index_ff  <= 4'd0;
         shift_data_ff <= 8'd0;
         us_rem_ff     <= 3'd0;
         prescale_ff   <= '0;
         poll_count_ff <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         ack_flag_ff   <= 1'b0;
         miss_ff       <= 1'b0;
         rx_hold_ff    <= 8'd0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         shift_data_ff <= shift_data_in;
         us_rem_ff     <= us_rem_in;
         prescale_ff   <= prescale_in;
         poll_count_ff <= poll_count_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in_next;
         ack_flag_ff   <= ack_flag_in;
         miss_ff       <= miss_in;
         rx_hold_ff    <= rx_hold_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/i2cbb_rsp_fifo.sv -----
`default_nettype none

module i2cbb_rsp_fifo
   import i2cbb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            full,
   output logic            empty,
   input  wire logic       pop,
   output result_type      pop_data
);

   result_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- design/i2c_bitbang_master_top.sv -----
// channel   handshake            payload
// req       req_push / req_full  req_op, req_tx_byte, req_send_ack, req_sda_in
// rsp       rsp_pop / rsp_empty  scl_out, sda_out, busy_res, done_res,
//                                ack_missing, rx_data
// csr       csr_valid/csr_ready  csr_index, csr_wdata
//
// one request per clock sustained while the response queue has room; a request
// taken into the request queue is stepped by the phase sequencer into the
// response queue, from which its response can be popped
// the sequencer retires one request per cycle whenever the response queue
// has room, so the rate is set by that single sequencer step
// synchronous reset empties both queues and puts the bus in the released state
// a stalled rsp side fills the response queue, then the request queue, then
// raises req_full
`default_nettype none

module i2c_bitbang_master_top
   import i2cbb_pkg::*;
#(
   parameter int PRESCALE_WIDTH = 10
)
(
   input  wire logic       clock,
   input  wire logic       reset,

   // request channel
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [2:0] req_op,
   input  wire logic [7:0] req_tx_byte,
   input  wire logic       req_send_ack,
   input  wire logic       req_sda_in,

   // response channel
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic            rsp_scl_out,
   output logic            rsp_sda_out,
   output logic            rsp_busy_res,
   output logic            rsp_done_res,
   output logic            rsp_ack_missing,
   output logic [7:0]      rsp_rx_data,

   // configuration write channel
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [9:0] csr_wdata
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       item_valid;
   logic       item_pop;
   item_type   item;
   logic       seq_push;
   result_type seq_result;
   logic       rsp_q_full;
   result_type rsp_head;

   // registers always take a write
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TICKS_PER_US: cfg_in.ticks_per_us = csr_wdata;
            CSR_ACK_TIMEOUT:  cfg_in.ack_timeout  = csr_wdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_us <= TICKS_PER_US_RST;
         cfg_ff.ack_timeout  <= ACK_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: op decode and request queue
   i2cbb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .op         (req_op),
      .tx_byte    (req_tx_byte),
      .send_ack   (req_send_ack),
      .sda_in     (req_sda_in),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   // back: bus phase sequencer, one request per step
   i2cbb_seq #(
      .PRESCALE_WIDTH (PRESCALE_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .rsp_full   (rsp_q_full),
      .rsp_push   (seq_push),
      .rsp_data   (seq_result)
   );

   // response queue decouples the sequencer from the consumer
   i2cbb_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (seq_push),
      .push_data (seq_result),
      .full      (rsp_q_full),
      .empty     (rsp_empty),
      .pop       (rsp_pop),
      .pop_data  (rsp_head)
   );

   assign rsp_scl_out     = rsp_head.scl_out;
   assign rsp_sda_out     = rsp_head.sda_out;
   assign rsp_busy_res    = rsp_head.busy_res;
   assign rsp_done_res    = rsp_head.done_res;
   assign rsp_ack_missing = rsp_head.ack_missing;
   assign rsp_rx_data     = rsp_head.rx_data;

endmodule

`default_nettype wire
